// ===== sv/sm3_pkg.sv =====
// Shared types, constants and helper functions for the SM3 hash engine.
`default_nettype none
package sm3_pkg;
  localparam int unsigned ROUNDS    = 64;
  localparam int unsigned RND_W     = $clog2(ROUNDS);
  localparam int unsigned BLK_WORDS = 16;
  localparam int unsigned IDX_W     = $clog2(BLK_WORDS);
  localparam int unsigned DIG_WORDS = 8;
  localparam int unsigned DCNT_W    = $clog2(DIG_WORDS + 1);

  localparam logic [31:0] T_LOW  = 32'h79cc4519;
  localparam logic [31:0] T_HIGH = 32'h7a879d8a;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [2:0]  FULL_CNT = 3'd4;

  localparam logic [31:0] SM3_IV [DIG_WORDS] = '{
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  cnt;
    logic        fin;
  } item_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

  function automatic logic [31:0] t_rot(input logic [RND_W-1:0] j);
    logic [31:0] t;
    t = (j < RND_W'(16)) ? T_LOW : T_HIGH;
    return rotl(t, j[4:0]);
  endfunction
endpackage
`default_nettype wire

// ===== sv/sm3_front.sv =====
// Input side: two-entry word queue that clamps byte counts and flags message ends.
`default_nettype none
module sm3_front import sm3_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [31:0] data_word_i,
  input  wire logic [2:0]  valid_bytes_i,
  input  wire logic        last_item_i,
  output logic             item_valid_o,
  output item_t            item_o,
  input  wire logic        item_take_i
);
  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_wr, do_rd;
  item_t      cls;

  always_comb begin
    cls.word = data_word_i;
    cls.cnt  = (valid_bytes_i > FULL_CNT) ? FULL_CNT : valid_bytes_i;
    cls.fin  = last_item_i || (valid_bytes_i < FULL_CNT);
  end

  assign full         = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = mem_q[rd_q];
  assign do_wr        = push && !full;
  assign do_rd        = item_take_i && item_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_wr) wr_q <= ~wr_q;
      if (do_rd) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(do_wr) - 2'(do_rd);
    end
  end
endmodule
`default_nettype wire

// ===== sv/sm3_core.sv =====
// Back end: block packing, padding, 64-round compression and digest word queue.
`default_nettype none
module sm3_core import sm3_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        item_valid_i,
  input  wire item_t       item_i,
  output logic             item_take_o,
  input  wire logic        pop,
  output logic             empty,
  output logic [31:0]      digest_word_o,
  output logic             digest_last_o
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PAD   = 7'b0000010,
    S_ZERO  = 7'b0000100,
    S_LEN   = 7'b0001000,
    S_CINIT = 7'b0010000,
    S_ROUND = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_e;

  state_e             state_q, state_d;
  logic [31:0]        blk_q [BLK_WORDS];
  logic [31:0]        cv_q  [DIG_WORDS];
  logic [31:0]        wk_q  [DIG_WORDS];
  logic [31:0]        ob_q  [DIG_WORDS];
  logic [DCNT_W-1:0]  ocnt_q;
  logic [IDX_W-1:0]   idx_q;
  logic [RND_W-1:0]   rnd_q;
  logic [63:0]        bits_q;
  logic [31:0]        padw_q;
  logic               pend_q, tail_q, final_q, dig_q;

  logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, wnew, pw_short;
  logic        early, take, ob_free;
  logic [IDX_W-1:0] idx_nx;

  assign ob_free = (ocnt_q == '0);
  assign take    = (state_q == S_IDLE) && item_valid_i && !dig_q;
  assign item_take_o = take;
  assign empty   = (ocnt_q == '0);
  assign digest_word_o = ob_q[0];
  assign digest_last_o = (ocnt_q == DCNT_W'(1));
  assign idx_nx  = idx_q + IDX_W'(1);

  always_comb begin
    early = (rnd_q < RND_W'(16));
    a12   = rotl(wk_q[0], 5'd12);
    ss1   = rotl(a12 + wk_q[4] + t_rot(rnd_q), 5'd7);
    ss2   = ss1 ^ a12;
    ff    = early ? (wk_q[0] ^ wk_q[1] ^ wk_q[2])
                  : ((wk_q[0] & wk_q[1]) | (wk_q[0] & wk_q[2]) | (wk_q[1] & wk_q[2]));
    gg    = early ? (wk_q[4] ^ wk_q[5] ^ wk_q[6])
                  : ((wk_q[4] & wk_q[5]) | (~wk_q[4] & wk_q[6]));
    tt1   = ff + wk_q[3] + ss2 + (blk_q[0] ^ blk_q[4]);
    tt2   = gg + wk_q[7] + ss1 + blk_q[0];
    wnew  = p1(blk_q[0] ^ blk_q[7] ^ rotl(blk_q[13], 5'd15))
            ^ rotl(blk_q[3], 5'd7) ^ blk_q[10];
    pw_short = (item_i.word & ~(32'hffffffff >> {item_i.cnt[1:0], 3'b000}))
               | ({24'd0, PAD_BYTE} << (5'd24 - {item_i.cnt[1:0], 3'b000}));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          if (idx_q == IDX_W'(BLK_WORDS - 1)) begin
            state_d = S_CINIT;
          end else if (item_i.cnt == FULL_CNT) begin
            if (item_i.fin) state_d = S_PAD;
          end else if (idx_q == IDX_W'(13)) begin
            state_d = S_LEN;
          end else begin
            state_d = S_ZERO;
          end
        end
      end
      S_PAD, S_ZERO: begin
        if (idx_q == IDX_W'(BLK_WORDS - 1)) state_d = S_CINIT;
        else if (idx_nx == IDX_W'(14))      state_d = S_LEN;
        else                                state_d = S_ZERO;
      end
      S_LEN:   state_d = S_CINIT;
      S_CINIT: state_d = S_ROUND;
      S_ROUND: if (rnd_q == RND_W'(ROUNDS - 1)) state_d = S_FIN;
      S_FIN: begin
        if (final_q)     state_d = S_IDLE;
        else if (pend_q) state_d = S_PAD;
        else if (tail_q) state_d = S_ZERO;
        else             state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: if (take) blk_q[idx_q] <= (item_i.cnt == FULL_CNT) ? item_i.word : pw_short;
      S_PAD:  blk_q[idx_q] <= padw_q;
      S_ZERO: blk_q[idx_q] <= '0;
      S_LEN: begin
        blk_q[14] <= bits_q[63:32];
        blk_q[15] <= bits_q[31:0];
      end
      S_ROUND: begin
        for (int i = 0; i < BLK_WORDS - 1; i++) blk_q[i] <= blk_q[i+1];
        blk_q[BLK_WORDS-1] <= wnew;
      end
      default: ;
    endcase
    if (state_q == S_CINIT) begin
      wk_q <= cv_q;
    end else if (state_q == S_ROUND) begin
      wk_q[0] <= tt1;
      wk_q[1] <= wk_q[0];
      wk_q[2] <= rotl(wk_q[1], 5'd9);
      wk_q[3] <= wk_q[2];
      wk_q[4] <= p0(tt2);
      wk_q[5] <= wk_q[4];
      wk_q[6] <= rotl(wk_q[5], 5'd19);
      wk_q[7] <= wk_q[6];
    end
    if (take) padw_q <= {PAD_BYTE, 24'd0};
    if (dig_q && ob_free) begin
      ob_q <= cv_q;
    end else if (pop && !empty) begin
      for (int i = 0; i < DIG_WORDS - 1; i++) ob_q[i] <= ob_q[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cv_q    <= SM3_IV;
      idx_q   <= '0;
      rnd_q   <= '0;
      bits_q  <= '0;
      pend_q  <= 1'b0;
      tail_q  <= 1'b0;
      final_q <= 1'b0;
      dig_q   <= 1'b0;
      ocnt_q  <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: begin
          if (take) begin
            bits_q <= bits_q + 64'({item_i.cnt, 3'b000});
            idx_q  <= idx_nx;
            if (item_i.cnt == FULL_CNT && idx_q == IDX_W'(BLK_WORDS - 1)) begin
              pend_q <= item_i.fin;
            end
            if (item_i.cnt != FULL_CNT && idx_q == IDX_W'(BLK_WORDS - 1)) begin
              tail_q <= 1'b1;
            end
          end
        end
        S_PAD, S_ZERO: begin
          idx_q  <= idx_nx;
          pend_q <= 1'b0;
          tail_q <= 1'b1;
        end
        S_LEN: begin
          idx_q   <= '0;
          final_q <= 1'b1;
        end
        S_CINIT: rnd_q <= '0;
        S_ROUND: rnd_q <= rnd_q + RND_W'(1);
        S_FIN: begin
          for (int i = 0; i < DIG_WORDS; i++) cv_q[i] <= cv_q[i] ^ wk_q[i];
          if (final_q) begin
            dig_q   <= 1'b1;
            final_q <= 1'b0;
            tail_q  <= 1'b0;
            bits_q  <= '0;
          end
        end
        default: ;
      endcase
      if (dig_q && ob_free) begin
        dig_q  <= 1'b0;
        cv_q   <= SM3_IV;
        ocnt_q <= DCNT_W'(DIG_WORDS);
      end else if (pop && !empty) begin
        ocnt_q <= ocnt_q - DCNT_W'(1);
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/sm3_hash_engine_unit.sv =====
// Top level of the SM3 hash engine.
// Words are queued in a two-entry input queue and packed into a 16-word block;
// each full block then goes through the round unit (a load step, 64 rounds
// at one per cycle, one chaining update) while no new words are taken in.
// Message end adds the padding words, one or two compressions and a digest
// load; the eight digest words then wait in an output queue while the next
// message is taken in.
`default_nettype none
module sm3_hash_engine_unit import sm3_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [31:0] data_word_i,
  input  wire logic [2:0]  valid_bytes_i,
  input  wire logic        last_item_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      digest_word_o,
  output logic             digest_last_o
);
  item_t item;
  logic  item_valid, item_take;

  sm3_front u_front (
    .clk_i, .rst_ni, .push, .full, .data_word_i, .valid_bytes_i, .last_item_i,
    .item_valid_o(item_valid), .item_o(item), .item_take_i(item_take)
  );

  sm3_core u_core (
    .clk_i, .rst_ni, .item_valid_i(item_valid), .item_i(item),
    .item_take_o(item_take), .pop, .empty, .digest_word_o, .digest_last_o
  );
endmodule
`default_nettype wire

// ===== sv/sm3_checker.sv =====
// Port-level checks for the SM3 hash engine, bound to the top level.
`default_nettype none
module sm3_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [31:0] digest_word_o,
  input wire logic        digest_last_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(digest_word_o)))
    else $error("digest word changed while waiting");
  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && digest_last_o) |=> empty)
    else $error("queue not empty after final digest word");
  a_mid_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !digest_last_o) |=> !empty)
    else $error("digest ended early");
endmodule

bind sm3_hash_engine_unit sm3_checker u_checker (
  .clk_i, .rst_ni, .empty, .pop, .digest_word_o, .digest_last_o
);
`default_nettype wire

// ===== sim/tb_sm3_hash_engine_unit.sv =====
// Testbench for the SM3 hash engine: random and directed messages against a local SM3 model.
`default_nettype none
module tb_sm3_hash_engine_unit import sm3_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] word;
    logic        fin;
  } digest_t;

  class digest_scoreboard;
    logic [31:0] chain [8];
    logic [31:0] blk [16];
    logic [5:0]  fill;
    logic [63:0] nbits;
    digest_t     pending [$];
    int          errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) chain[i] = SM3_IV[i];
      fill = '0;
      nbits = '0;
    endfunction

    function logic [31:0] rol(logic [31:0] x, int n);
      n = n % 32;
      if (n == 0) return x;
      return (x << n) | (x >> (32 - n));
    endfunction

    function void compress();
      logic [31:0] w [68];
      logic [31:0] r [8];
      logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, t;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 68; i++) begin
        t = w[i-16] ^ w[i-9] ^ rol(w[i-3], 15);
        w[i] = (t ^ rol(t, 15) ^ rol(t, 23)) ^ rol(w[i-13], 7) ^ w[i-6];
      end
      for (int i = 0; i < 8; i++) r[i] = chain[i];
      for (int j = 0; j < 64; j++) begin
        t = (j < 16) ? T_LOW : T_HIGH;
        a12 = rol(r[0], 12);
        ss1 = rol(a12 + r[4] + rol(t, j), 7);
        ss2 = ss1 ^ a12;
        if (j < 16) begin
          ff = r[0] ^ r[1] ^ r[2];
          gg = r[4] ^ r[5] ^ r[6];
        end else begin
          ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
          gg = (r[4] & r[5]) | (~r[4] & r[6]);
        end
        tt1 = ff + r[3] + ss2 + (w[j] ^ w[j+4]);
        tt2 = gg + r[7] + ss1 + w[j];
        r[3] = r[2]; r[2] = rol(r[1], 9); r[1] = r[0]; r[0] = tt1;
        r[7] = r[6]; r[6] = rol(r[5], 19); r[5] = r[4];
        r[4] = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
      end
      for (int i = 0; i < 8; i++) chain[i] ^= r[i];
    endfunction

    function void add_byte(logic [7:0] b);
      logic [31:0] prev;
      prev = (fill[1:0] == 2'd0) ? 32'd0 : blk[fill[5:2]];
      blk[fill[5:2]] = prev | (32'(b) << (24 - 8 * fill[1:0]));
      fill++;
      if (fill == 6'd0) compress();
    endfunction

    function void note_word(logic [31:0] word, logic [2:0] cnt, logic fin);
      int n;
      n = (cnt > FULL_CNT) ? 4 : cnt;
      for (int k = 0; k < n; k++) begin
        add_byte(word[31 - 8 * k -: 8]);
        nbits += 64'd8;
      end
      if (n == 4 && !fin) return;
      add_byte(PAD_BYTE);
      while (fill != 6'd56) add_byte(8'h00);
      blk[14] = nbits[63:32];
      blk[15] = nbits[31:0];
      compress();
      for (int k = 0; k < 8; k++) pending.push_back('{chain[k], k == 7});
      restart();
    endfunction

    function void check_word(logic [31:0] word, logic fin);
      digest_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected digest word %h last %b", $time, word, fin);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (word !== e.word) begin
        $display("%0t digest word: expected %h actual %h", $time, e.word, word);
        errors++;
      end
      if (fin !== e.fin) begin
        $display("%0t digest last: expected %b actual %b", $time, e.fin, fin);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] data_word_i = '0;
  logic [2:0]  valid_bytes_i = '0;
  logic        last_item_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] digest_word_o;
  logic        digest_last_o;

  digest_scoreboard sb = new();
  int  idle_pct = 16;
  bit  hold_pop = 1'b0;

  sm3_hash_engine_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic send_word(logic [31:0] word, logic [2:0] cnt, logic fin);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    data_word_i <= word;
    valid_bytes_i <= cnt;
    last_item_i <= fin;
    do @(posedge clk_i); while (full);
    sb.note_word(word, cnt, fin);
  endtask

  task automatic send_message(int nwords, bit closing_short);
    for (int i = 0; i < nwords; i++) send_word($urandom, 3'd4, 1'b0);
    if (closing_short) send_word($urandom, 3'($urandom_range(3)), $urandom_range(1));
    else send_word($urandom, 3'd4, 1'b1);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check_word(digest_word_o, digest_last_o);
    pop <= !hold_pop && ($urandom_range(99) >= idle_pct);
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: empty message, short endings, oversize counts, block boundaries
    send_word(32'h0, 3'd0, 1'b1);
    send_word(32'hffffffff, 3'd0, 1'b0);
    send_word(32'h61626300, 3'd3, 1'b0);
    send_word(32'hffffffff, 3'd1, 1'b1);
    send_word(32'hffffffff, 3'd2, 1'b0);
    send_word(32'h00000000, 3'd4, 1'b1);
    send_word(32'hffffffff, 3'd7, 1'b1);
    send_word(32'haaaaaaaa, 3'd5, 1'b0);
    send_word(32'h55555555, 3'd6, 1'b1);
    send_message(13, 1'b0);
    send_message(15, 1'b1);
    wait_drained();
    // receiver holds off while the sender sends four short messages
    hold_pop = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_pop = 1'b0;
      end
      begin
        repeat (4) send_message($urandom_range(3), $urandom_range(1));
        push <= 1'b0;
      end
    join
    wait_drained();
    // random messages, with one stretch of no idling
    for (int m = 0; m < 14; m++) begin
      idle_pct = (m >= 5 && m < 8) ? 0 : 16;
      if ($urandom_range(9) == 0) send_word($urandom, 3'($urandom_range(7)), 1'b1);
      else if ($urandom_range(5) == 0) send_message($urandom_range(14, 18), $urandom_range(1));
      else send_message($urandom_range(6), $urandom_range(1));
    end
    idle_pct = 16;
    wait_drained();
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
